### src/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, the reciprocal table, the bus type and the factor rounding for the sine pipeline.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int ANGLE_W  = 32;               // Q3.29 in, Q1.30 out
	localparam int SQ_W     = 2 * ANGLE_W;      // exact square, Q.58
	localparam int X2_W     = 45;               // x*x in Q.40, at most 2^44
	localparam int X2_SH    = 18;               // Q.58 -> Q.40
	localparam int T0_SH    = 11;               // Q.29 -> Q.40
	localparam int TERM_W   = 46;               // term magnitude, Q.40
	localparam int F_W      = 42;               // factor x*x/(k(k-1)), Q.40
	localparam int SUM_W    = 48;               // signed running sum, Q.40
	localparam int RECIP_W  = 30;
	localparam int RECIP_SH = 32;               // reciprocals are Q.32
	localparam int TERM_SH  = 40;
	localparam int OUT_SH   = 10;               // Q.40 -> Q.30

	// operand splits for the partial products
	localparam int TLO_W    = 23;
	localparam int FLO_W    = 21;
	localparam int X2LO_W   = 23;

	localparam int FP_LO_W  = X2LO_W + RECIP_W;
	localparam int FP_HI_W  = X2_W - X2LO_W + RECIP_W;
	localparam int FPF_W    = X2_W + RECIP_W + 1;

	// round(2^32 / (k(k-1))) for k = 3, 5, ..., 27
	localparam int RECIP_N = 13;
	localparam logic [RECIP_W-1:0] RECIP_TBL [RECIP_N] = '{
		30'd715827883,  // k = 3
		30'd214748365,  // k = 5
		30'd102261126,  // k = 7
		30'd59652324,   // k = 9
		30'd39045157,   // k = 11
		30'd27531842,   // k = 13
		30'd20452225,   // k = 15
		30'd15790321,   // k = 17
		30'd12558384,   // k = 19
		30'd10226113,   // k = 21
		30'd8488078,    // k = 23
		30'd7158279,    // k = 25
		30'd6118187     // k = 27
	};

	// what travels between series stages; sum excludes the term in mag
	typedef struct packed {
		logic [X2_W-1:0]   x2;
		logic [F_W-1:0]    f;
		logic [TERM_W-1:0] mag;
		logic              neg;
		logic [SUM_W-1:0]  sum;
	} term_bus_t;

	// join the two halves of x2*recip and round Q.72 -> Q.40
	function automatic logic [F_W-1:0] f_combine(input logic [FP_LO_W-1:0] lo,
	                                             input logic [FP_HI_W-1:0] hi);
		logic [FPF_W-1:0] full;
		full = FPF_W'(lo) + (FPF_W'(hi) << X2LO_W) + (FPF_W'(1) << (RECIP_SH - 1));
		return full[RECIP_SH +: F_W];
	endfunction

endpackage

### src/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Five stages: magnitude and sign, square, round to Q.40, factor for k = 3.
// ----------------------------------------------------------------------------
module sts_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [sts_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	output sts_pkg::term_bus_t                  out_bus
);
	import sts_pkg::*;

	logic [4:0]            vld_q;
	logic [ANGLE_W-1:0]    mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;
	logic                  neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SQ_W-1:0]       sq_s2;
	logic [SQ_W-1:0]       sq_rnd;
	logic [X2_W-1:0]       x2_s3, x2_s4, x2_s5;
	logic [FP_LO_W-1:0]    fp_lo_s4;
	logic [FP_HI_W-1:0]    fp_hi_s4;
	logic [F_W-1:0]        f_s5;
	logic [ANGLE_W-1:0]    angle_u;

	assign angle_u = angle;
	assign sq_rnd  = sq_s2 + (SQ_W'(1) << (X2_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= angle_u[ANGLE_W-1] ? (~angle_u + 1'b1) : angle_u;
			neg_s1   <= angle_u[ANGLE_W-1];

			sq_s2    <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
			mag_s2   <= mag_s1;
			neg_s2   <= neg_s1;

			x2_s3    <= sq_rnd[X2_SH +: X2_W];
			mag_s3   <= mag_s2;
			neg_s3   <= neg_s2;

			fp_lo_s4 <= FP_LO_W'(x2_s3[X2LO_W-1:0]) * FP_LO_W'(RECIP_TBL[0]);
			fp_hi_s4 <= FP_HI_W'(x2_s3[X2_W-1:X2LO_W]) * FP_HI_W'(RECIP_TBL[0]);
			x2_s4    <= x2_s3;
			mag_s4   <= mag_s3;
			neg_s4   <= neg_s3;

			f_s5     <= f_combine(fp_lo_s4, fp_hi_s4);
			x2_s5    <= x2_s4;
			mag_s5   <= mag_s4;
			neg_s5   <= neg_s4;
		end
	end

	assign out_valid   = vld_q[4];
	assign out_bus.x2  = x2_s5;
	assign out_bus.f   = f_s5;
	assign out_bus.mag = TERM_W'(mag_s5) << T0_SH;
	assign out_bus.neg = neg_s5;
	assign out_bus.sum = '0;

endmodule

### src/sts_term.sv
// ----------------------------------------------------------------------------
// sts_term
// One series step in three stages: folds the incoming term into the sum,
// forms the next term |t|*f >> 40, and the factor for the step after.
// ----------------------------------------------------------------------------
module sts_term #(
	parameter int TERM_IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  sts_pkg::term_bus_t in_bus,
	output logic               out_valid,
	output sts_pkg::term_bus_t out_bus
);
	import sts_pkg::*;

	localparam int THI_W  = TERM_W - TLO_W;
	localparam int FHI_W  = F_W - FLO_W;
	localparam int PP_W   = ((THI_W > TLO_W) ? THI_W : TLO_W)
	                      + ((FHI_W > FLO_W) ? FHI_W : FLO_W);
	localparam int A_W    = PP_W + FLO_W + 1;
	localparam int FULL_W = A_W + TLO_W + 1;
	localparam logic [RECIP_W-1:0] R_NEXT = RECIP_TBL[TERM_IDX+1];

	logic [2:0]            vld_q;
	logic [X2_W-1:0]       x2_s1, x2_s2, x2_s3;
	logic                  neg_s1, neg_s2, neg_s3;
	logic [SUM_W-1:0]      sum_s1, sum_s2, sum_s3;
	logic [PP_W-1:0]       pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic [FP_LO_W-1:0]    fp_lo_s1;
	logic [FP_HI_W-1:0]    fp_hi_s1;
	logic [A_W-1:0]        a_s2, b_s2;
	logic [F_W-1:0]        f_s2, f_s3;
	logic [TERM_W-1:0]     mag_s3;
	logic [FULL_W-1:0]     full;
	logic [SUM_W-1:0]      mag_ext;

	assign mag_ext = SUM_W'(in_bus.mag);
	assign full    = FULL_W'(a_s2) + (FULL_W'(b_s2) << TLO_W)
	               + (FULL_W'(1) << (TERM_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: partial products, sum update
			pp_ll_s1 <= PP_W'(in_bus.mag[TLO_W-1:0]) * PP_W'(in_bus.f[FLO_W-1:0]);
			pp_lh_s1 <= PP_W'(in_bus.mag[TLO_W-1:0]) * PP_W'(in_bus.f[F_W-1:FLO_W]);
			pp_hl_s1 <= PP_W'(in_bus.mag[TERM_W-1:TLO_W]) * PP_W'(in_bus.f[FLO_W-1:0]);
			pp_hh_s1 <= PP_W'(in_bus.mag[TERM_W-1:TLO_W]) * PP_W'(in_bus.f[F_W-1:FLO_W]);
			fp_lo_s1 <= FP_LO_W'(in_bus.x2[X2LO_W-1:0]) * FP_LO_W'(R_NEXT);
			fp_hi_s1 <= FP_HI_W'(in_bus.x2[X2_W-1:X2LO_W]) * FP_HI_W'(R_NEXT);
			sum_s1   <= in_bus.neg ? (in_bus.sum - mag_ext) : (in_bus.sum + mag_ext);
			neg_s1   <= ~in_bus.neg;  // series alternates sign
			x2_s1    <= in_bus.x2;

			// stage 2: partial sums
			a_s2     <= A_W'(pp_ll_s1) + (A_W'(pp_lh_s1) << FLO_W);
			b_s2     <= A_W'(pp_hl_s1) + (A_W'(pp_hh_s1) << FLO_W);
			f_s2     <= f_combine(fp_lo_s1, fp_hi_s1);
			sum_s2   <= sum_s1;
			neg_s2   <= neg_s1;
			x2_s2    <= x2_s1;

			// stage 3: round Q.80 -> Q.40
			mag_s3   <= full[TERM_SH +: TERM_W];
			f_s3     <= f_s2;
			sum_s3   <= sum_s2;
			neg_s3   <= neg_s2;
			x2_s3    <= x2_s2;
		end
	end

	assign out_valid   = vld_q[2];
	assign out_bus.x2  = x2_s3;
	assign out_bus.f   = f_s3;
	assign out_bus.mag = mag_s3;
	assign out_bus.neg = neg_s3;
	assign out_bus.sum = sum_s3;

endmodule

### src/sts_final.sv
// ----------------------------------------------------------------------------
// sts_final
// Adds the last term, takes the magnitude, rounds to Q1.30 and saturates.
// ----------------------------------------------------------------------------
module sts_final (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  sts_pkg::term_bus_t          in_bus,
	output logic                        out_valid,
	output logic [sts_pkg::ANGLE_W-1:0] out_value
);
	import sts_pkg::*;

	localparam int R_W = SUM_W - OUT_SH + 1;

	logic [1:0]         vld_q;
	logic [SUM_W-1:0]   sum_s1;
	logic [SUM_W-1:0]   mag_s2;
	logic               neg_s2;
	logic [SUM_W-1:0]   mag_ext;
	logic [SUM_W:0]     rnd;
	logic [R_W-1:0]     r;

	assign mag_ext = SUM_W'(in_bus.mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= in_bus.neg ? (in_bus.sum - mag_ext) : (in_bus.sum + mag_ext);
			neg_s2 <= sum_s1[SUM_W-1];
			mag_s2 <= sum_s1[SUM_W-1] ? (~sum_s1 + 1'b1) : sum_s1;
		end
	end

	// round magnitude half away from zero, then clamp
	always_comb begin
		rnd = (SUM_W+1)'(mag_s2) + ((SUM_W+1)'(1) << (OUT_SH - 1));
		r   = rnd[OUT_SH +: R_W];
		if (neg_s2) begin
			if (r > (R_W'(1) << (ANGLE_W - 1)))
				out_value = {1'b1, {(ANGLE_W-1){1'b0}}};
			else
				out_value = ~r[ANGLE_W-1:0] + 1'b1;
		end else begin
			if (r > ((R_W'(1) << (ANGLE_W - 1)) - 1'b1))
				out_value = {1'b0, {(ANGLE_W-1){1'b1}}};
			else
				out_value = r[ANGLE_W-1:0];
		end
	end

	assign out_valid = vld_q[1];

endmodule

### src/sine_taylor_series.sv
// ----------------------------------------------------------------------------
// sine_taylor_series
// Pipelined sin(x) by the truncated Maclaurin series, Q3.29 in, Q1.30 out.
// ----------------------------------------------------------------------------
// Input channel: angle with in_valid / in_ready. Output channel: sine_value
// with out_valid / out_ready. Each item is taken when valid and ready are
// both high at a rising clock edge.
// Throughput: one item per cycle, sustained, while the receiver keeps up.
// From acceptance to out_valid an item passes five front stages (abs,
// 32x32 square, rounding, two for the first factor), three stages for each
// of the ODD_POWER_LIMIT/2 series terms (split partial products, partial
// sums, rounding), two closing stages, then the output register.
// The output register is backed by a one-item skid buffer; the pipeline
// advances only while the skid buffer is empty, so in_ready comes straight
// from a flop. When the output register is full, out_ready is low and a result
// reaches the end of the pipeline, it goes to the skid buffer and every stage
// then holds in place until the sink takes an item; nothing is dropped or repeated.
// Reset (arst_n low) clears all valid bits; no angle reduction is done and
// any 32-bit angle is evaluated as is, with the result saturated.
// ----------------------------------------------------------------------------
module sine_taylor_series #(
	parameter int ODD_POWER_LIMIT = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sts_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sts_pkg::ANGLE_W-1:0]  sine_value
);
	import sts_pkg::*;

	localparam int NUM_TERMS = ODD_POWER_LIMIT / 2;

	logic                  en;
	logic [NUM_TERMS:0]    vld;
	term_bus_t             bus [NUM_TERMS+1];
	logic                  fin_valid;
	logic [ANGLE_W-1:0]    fin_value;
	logic                  push;

	logic                  out_valid_q;
	logic [ANGLE_W-1:0]    out_data_q;
	logic                  skid_valid_q;
	logic [ANGLE_W-1:0]    skid_data_q;

	assign en       = ~skid_valid_q;
	assign in_ready = en;
	assign push     = en & fin_valid;

	sts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.angle    (angle),
		.out_valid(vld[0]),
		.out_bus  (bus[0])
	);

	for (genvar j = 0; j < NUM_TERMS; j++) begin : g_term
		sts_term #(
			.TERM_IDX(j)
		) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (vld[j]),
			.in_bus   (bus[j]),
			.out_valid(vld[j+1]),
			.out_bus  (bus[j+1])
		);
	end

	sts_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld[NUM_TERMS]),
		.in_bus   (bus[NUM_TERMS]),
		.out_valid(fin_valid),
		.out_value(fin_value)
	);

	// output register with skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : fin_value;
		end else if (push) begin
			skid_data_q <= fin_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign sine_value = out_data_q;

endmodule

### verif/sine_taylor_series_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_taylor_series_tb
// Self-checking bench for the pipelined Maclaurin sine block.
// Angles go in through a valid/ready source with random gaps, and the sink
// stalls at random. Every accepted angle is run through a bit-exact model of
// the fixed-point series. Each result is checked in order against it.
// ----------------------------------------------------------------------------

class sine_scoreboard;
	int                 terms_limit;
	logic signed [31:0] sine_q[$];
	logic signed [31:0] angle_q[$];
	int                 n_angles;
	int                 n_checked;
	int                 n_saturated;
	int                 n_errors;

	function new(int opl);
		terms_limit = opl;
		n_angles    = 0;
		n_checked   = 0;
		n_saturated = 0;
		n_errors    = 0;
	endfunction

	// |a*b| >> sh with the magnitude rounded half away from zero, sign restored
	function longint round_mul(longint a, longint b, int unsigned sh);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] p;
		logic [62:0]  r;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? 64'(-a) : 64'(a);
		ub  = (b < 0) ? 64'(-b) : 64'(b);
		p   = {64'd0, ua} * {64'd0, ub};
		p   = p + (128'd1 << (sh - 1));
		p   = p >> sh;
		r   = p[62:0];
		return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

	// 1/(k(k-1)) in Q.32, rounded
	function longint recip_q32(longint d);
		return ((64'sd1 <<< 32) + d / 2) / d;
	endfunction

	function logic signed [31:0] series_sine(logic signed [31:0] a);
		longint      x;
		longint      x2;
		longint      term;
		longint      sum;
		longint      f;
		longint      mag;
		longint      r;
		longint      res;
		logic [63:0] sq;
		int          k;
		x    = a;
		sq   = 64'(x * x);
		x2   = $signed((sq + (64'd1 << 17)) >> 18);
		term = x * 2048;
		sum  = term;
		// the k = 3 term is added only when the limit is above 1
		for (k = 3; k - 2 < terms_limit; k += 2) begin
			f    = round_mul(x2, recip_q32(longint'(k) * (k - 1)), 32);
			term = -round_mul(term, f, 40);
			sum  = sum + term;
		end
		mag = (sum < 0) ? -sum : sum;
		r   = (mag + 512) >>> 10;
		if (sum < 0) begin
			res = (r > 64'sd2147483648) ? -64'sd2147483648 : -r;
		end else begin
			res = (r > 64'sd2147483647) ? 64'sd2147483647 : r;
		end
		return res[31:0];
	endfunction

	function void note_angle(logic signed [31:0] a);
		logic signed [31:0] s;
		s = series_sine(a);
		if (s == 32'sh7FFFFFFF || s == 32'sh80000000)
			n_saturated++;
		sine_q.push_back(s);
		angle_q.push_back(a);
		n_angles++;
	endfunction

	function void check_sine(logic signed [31:0] v);
		logic signed [31:0] s;
		logic signed [31:0] a;
		if (sine_q.size() == 0) begin
			n_errors++;
			$display("%0t: unexpected sine_value %0d (0x%08h) with no angle pending",
				$time, v, v);
			return;
		end
		s = sine_q.pop_front();
		a = angle_q.pop_front();
		n_checked++;
		if (v !== s) begin
			n_errors++;
			$display("%0t: angle 0x%08h: sine_value expected %0d (0x%08h), got %0d (0x%08h)",
				$time, a, s, s, v, v);
		end
	endfunction

	function int pending();
		return sine_q.size();
	endfunction
endclass

module sine_taylor_series_tb;

	localparam int OPL       = 12;
	localparam int LATENCY   = 3 * (OPL / 2) + 7;
	localparam int N_RANDOM  = 1650;
	localparam int MAX_CYCLES = 800000;

	localparam logic signed [31:0] ONE_Q29     = 32'sd536870912;
	localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
	localparam logic signed [31:0] BIG_Q29     = 32'sd1879048192;   // 3.5

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [sts_pkg::ANGLE_W-1:0] angle;
	logic out_valid;
	logic out_ready;
	logic signed [sts_pkg::ANGLE_W-1:0] sine_value;

	sine_scoreboard sb;
	bit             calm;       // no idling on either side while set
	int             cycles = 0;
	int             n_directed;

	sine_taylor_series #(
		.ODD_POWER_LIMIT(OPL)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.angle     (angle),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sine_value(sine_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("%0t: timeout, %0d results still pending", $time, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int gap_len();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 88)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [31:0] random_angle();
		int unsigned sel;
		logic [31:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 45)
			return $urandom;
		if (sel < 70)
			m = $urandom_range(0, HALF_PI_Q29);
		else if (sel < 85)
			m = $urandom_range(BIG_Q29, 32'h7FFFFFFF);
		else
			m = $urandom_range(0, 4095);
		return $urandom_range(0, 1) ? -$signed(m) : $signed(m);
	endfunction

	task automatic send_angle(input logic signed [31:0] a);
		int gap;
		gap = calm ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		angle    <= a;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_angle(angle);
			if (out_valid && out_ready)
				sb.check_sine(sine_value);
		end
	end

	// sink: bursts of ready broken by random stalls
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(1, 40);
			repeat (run) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end
			stall = calm ? 0 : gap_len();
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	initial begin
		logic signed [31:0] directed[$];
		int i;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		angle    = '0;
		calm     = 1'b0;
		sb       = new(OPL);
		directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd2048, 32'sh7FFFFFFF, 32'sh80000000,
			ONE_Q29, -ONE_Q29, HALF_PI_Q29, -HALF_PI_Q29, PI_Q29, -PI_Q29,
			32'sd1610612736, -32'sd1610612736, BIG_Q29, -BIG_Q29,
			32'sh55555555, 32'shAAAAAAAA, 32'sh80000001};
		n_directed = directed.size();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[j])
			send_angle(directed[j]);
		for (i = 0; i < N_RANDOM; i++) begin
			calm = ((i / 150) % 3) == 1;
			send_angle(random_angle());
		end
		@(negedge clk);
		in_valid <= 1'b0;
		calm = 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		sb.n_errors += sb.pending();

		$display("Angles sent: %0d (%0d directed edge cases, rest random over the full Q3.29 range)",
			sb.n_angles, n_directed);
		$display("Results checked: %0d, of which %0d at full scale; mismatches: %0d",
			sb.n_checked, sb.n_saturated, sb.n_errors);
		if (sb.n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
src/sts_pkg.sv
src/sts_front.sv
src/sts_term.sv
src/sts_final.sv
src/sine_taylor_series.sv
verif/sine_taylor_series_tb.sv
